[rtl/core/trimmed_mean_of_eight_samples_assert.svh]
// ----------------------------------------------------------------------------
// Trimmed mean assertion macros
// Shared property forms for the trimmed mean filter checks.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_OF_EIGHT_SAMPLES_ASSERT_SVH
`define TRIMMED_MEAN_OF_EIGHT_SAMPLES_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define TMEAN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trimmed mean: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define TMEAN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trimmed mean: next-cycle check failed");

`endif

[rtl/core/tmean_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed mean package
// Group constants and the control bundle handed to each sorting cell.
// ----------------------------------------------------------------------------
package tmean_pkg;

  localparam int unsigned GroupSize = 8;
  localparam int unsigned KeepCount = 4;
  localparam int unsigned FirstKept = 2;
  localparam int unsigned CountW    = $clog2(GroupSize);

  // Control bundle for each cell of the insertion chain; load is common to all cells.
  typedef struct packed {
    logic load;      // a sample transfer happens this cycle
    logic occupied;  // the cell holds a sample of the current group
  } cell_ctrl_t;

endpackage

[rtl/core/trimmed_mean_of_eight_samples.sv]
`timescale 1ns / 1ps
// The eighth sample's transfer sets done_q; the mean is then registered into mean_q,
// and out_valid_o rises, once the output register is free.
// Throughput: one sample per cycle while in_stall_o is low; the eight-cell insertion chain sorts as samples arrive.
// The input stalls only while a finished mean is pending and the output register is held.
// Reset clears the sample count and the output valid; cell contents stay undefined.
// ----------------------------------------------------------------------------
// Trimmed mean of eight samples
// Sorts each group of eight samples and returns the mean of the middle four.
// ----------------------------------------------------------------------------
`include "trimmed_mean_of_eight_samples_assert.svh"

module trimmed_mean_of_eight_samples #(
  parameter int unsigned SAMPLE_WIDTH = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SAMPLE_WIDTH-1:0] trimmed_mean_o
);

  localparam int unsigned GroupSize = tmean_pkg::GroupSize;
  localparam int unsigned CountW    = tmean_pkg::CountW;
  localparam int unsigned SumW      = SAMPLE_WIDTH + 2;
  localparam logic [CountW-1:0] LastCount = CountW'(GroupSize - 1);

  logic                    in_xfer;
  logic                    out_load;
  logic [CountW-1:0]       count_q, count_d;
  logic [CountW-1:0]       count_inc;
  logic                    done_q, done_d;
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] mean_q, mean_d;
  logic [SumW-1:0]         sum;

  logic [SAMPLE_WIDTH-1:0] cell_value [GroupSize];
  logic                    cell_take  [GroupSize];

  // A finished group waits in done_q until the output register is free.
  assign out_load   = done_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = done_q && !out_load;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign count_inc  = count_q + CountW'(1);

  for (genvar i = 0; i < GroupSize; i++) begin : g_cell
    tmean_pkg::cell_ctrl_t ctrl;
    logic [SAMPLE_WIDTH-1:0] left_value;
    logic                    left_take;

    assign ctrl.load     = in_xfer;
    assign ctrl.occupied = CountW'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_take  = 1'b0;
    end else begin : g_rest
      assign left_value = cell_value[i-1];
      assign left_take  = cell_take[i-1];
    end

    tmean_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .sample_i    (sample_i),
      .left_value_i(left_value),
      .left_take_i (left_take),
      .value_o     (cell_value[i]),
      .take_o      (cell_take[i])
    );
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < tmean_pkg::KeepCount; k++) begin
      sum = sum + SumW'(cell_value[tmean_pkg::FirstKept + k]);
    end
  end

  always_comb begin
    count_d     = count_q;
    done_d      = done_q && !out_load;
    out_valid_d = out_valid_q;
    mean_d      = mean_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      mean_d      = sum[SumW-1:2];
    end
    if (in_xfer) begin
      if (count_q == LastCount) begin
        count_d = '0;
        done_d  = 1'b1;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
  end

  assign out_valid_o    = out_valid_q;
  assign trimmed_mean_o = mean_q;

  `TMEAN_ASSERT_NEXT(a_group_done, in_xfer && (count_q == LastCount), done_q && (count_q == '0))
  `TMEAN_ASSERT_NEXT(a_count_step, in_xfer && (count_q != LastCount), count_q == $past(count_inc))
  `TMEAN_ASSERT_NOW(a_pending_stall, done_q && out_valid_o && out_stall_i, in_stall_o)
  `TMEAN_ASSERT_NEXT(a_result_after_done, done_q && !in_stall_o, out_valid_o)

endmodule

[rtl/core/tmean_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed mean sorting cell
// One slot of the insertion chain; takes the new sample or its left neighbour.
// ----------------------------------------------------------------------------
module tmean_cell #(
  parameter int unsigned SAMPLE_WIDTH = 10
) (
  input  logic                    clk_i,
  input  tmean_pkg::cell_ctrl_t   ctrl_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [SAMPLE_WIDTH-1:0] left_value_i,
  input  logic                    left_take_i,
  output logic [SAMPLE_WIDTH-1:0] value_o,
  output logic                    take_o
);

  logic [SAMPLE_WIDTH-1:0] value_q, value_d;

  // An empty slot, or one holding a larger value, lies at or above the
  // insertion point. Equal values stay below the new sample.
  assign take_o = !ctrl_i.occupied || (value_q > sample_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      if (left_take_i) begin
        value_d = left_value_i;
      end else if (take_o) begin
        value_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
